@@ design/pulse_flow_totalizer_macros.svh @@
// Assertion macros for the pulse flow totalizer.
`ifndef PULSE_FLOW_TOTALIZER_MACROS_SVH
`define PULSE_FLOW_TOTALIZER_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PFT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pulse_flow_totalizer: assertion failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define PFT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pulse_flow_totalizer: assertion failed");

`endif

@@ design/pft_pkg.sv @@
// Shared constants and controller/datapath types for the pulse flow totalizer.
package pft_pkg;

    localparam int PULSE_COUNT_BITS_DEF = 16;

    localparam int WINDOW_W   = 16;
    localparam int CAL_W      = 14;
    localparam int TIME_W     = 32;
    localparam int TOTAL_W    = 32;
    localparam int CFG_ADDR_W = 1;
    localparam int CFG_DATA_W = 16;

    localparam int SCALE   = 500;
    localparam int SCALE_W = 9;
    localparam int DEN_W   = TIME_W + CAL_W + 2;

    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1000;
    localparam logic [CAL_W-1:0]    CAL_RESET    = 14'd75;

    localparam logic [CFG_ADDR_W-1:0] CFG_WINDOW = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CAL    = 1'b1;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    typedef struct packed {
        logic take;
        logic mul;
        logic scale;
        logic step;
        logic add;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
    } t_dp_stat;

endpackage

@@ design/pft_ctrl.sv @@
// Sequencing controller: item intake, multiply, divide and result handoff.
module pft_ctrl #(
    parameter int PULSE_COUNT_BITS = pft_pkg::PULSE_COUNT_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  pft_pkg::t_dp_stat i_stat,
    output pft_pkg::t_dp_cmd  o_cmd
);

    localparam int NUM_W = PULSE_COUNT_BITS + pft_pkg::WINDOW_W + pft_pkg::SCALE_W;
    localparam int CNT_W = $clog2(NUM_W);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SCALE,
        S_DIV,
        S_ADD
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_cnt;
    logic             r_out_valid;
    logic             out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        o_cmd.take  = (r_state == S_IDLE) && i_in_valid;
        o_cmd.mul   = (r_state == S_MUL);
        o_cmd.scale = (r_state == S_SCALE);
        o_cmd.step  = (r_state == S_DIV);
        o_cmd.add   = (r_state == S_ADD) && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.add) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && i_stat.close) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SCALE;
                end
                S_SCALE: begin
                    r_cnt   <= CNT_W'(NUM_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_state <= S_ADD;
                    end else begin
                        r_cnt <= r_cnt - 1'b1;
                    end
                end
                S_ADD: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

@@ design/pft_dp.sv @@
// Datapath: configuration, pulse tally, window timing, flow divider and total.
module pft_dp #(
    parameter int PULSE_COUNT_BITS = pft_pkg::PULSE_COUNT_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pft_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [pft_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_operation,
    input  logic [pft_pkg::TIME_W-1:0]        i_now_ms,
    input  logic                              i_pin_level,
    input  pft_pkg::t_dp_cmd                  i_cmd,
    output pft_pkg::t_dp_stat                 o_stat,
    output logic [pft_pkg::TOTAL_W-1:0]       o_total_ml
);

    localparam int WIN_W  = pft_pkg::WINDOW_W;
    localparam int CAL_W  = pft_pkg::CAL_W;
    localparam int TIME_W = pft_pkg::TIME_W;
    localparam int TOT_W  = pft_pkg::TOTAL_W;
    localparam int DEN_W  = pft_pkg::DEN_W;
    localparam int PROD_W = PULSE_COUNT_BITS + WIN_W;
    localparam int NUM_W  = PROD_W + pft_pkg::SCALE_W;
    localparam int RAW_W  = TIME_W + CAL_W;

    logic [WIN_W-1:0]            r_window;
    logic [CAL_W-1:0]            r_cal;
    logic                        r_prev;
    logic [PULSE_COUNT_BITS-1:0] r_tally;
    logic [TIME_W-1:0]           r_start;
    logic [TOT_W-1:0]            r_total;
    logic [TOT_W-1:0]            r_out;

    logic [TIME_W-1:0] r_elapsed;
    logic [PROD_W-1:0] r_wt;
    logic [NUM_W-1:0]  r_num;
    logic [RAW_W-1:0]  r_den_raw;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_quo;

    logic [TIME_W-1:0] elapsed;
    logic              close;
    logic              fall;
    logic [DEN_W:0]    rem_sh;
    logic [DEN_W:0]    diff;
    logic              ge;
    logic [TOT_W-1:0]  q_low;
    logic [TOT_W-1:0]  n_total;

    assign elapsed      = i_now_ms - r_start;
    assign close        = elapsed > {{(TIME_W - WIN_W){1'b0}}, r_window};
    assign o_stat.close = (i_operation == pft_pkg::OP_SAMPLE) && close;
    assign fall         = r_prev && !i_pin_level;

    assign rem_sh  = {r_rem, r_quo[NUM_W-1]};
    assign diff    = rem_sh - {1'b0, r_den};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign q_low   = (r_den == '0) ? '0 : r_quo[TOT_W-1:0];
    assign n_total = r_total + q_low;

    assign o_total_ml = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= pft_pkg::WINDOW_RESET;
            r_cal    <= pft_pkg::CAL_RESET;
            r_prev   <= 1'b0;
            r_tally  <= '0;
            r_start  <= '0;
            r_total  <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    pft_pkg::CFG_WINDOW: r_window <= i_cfg_data[WIN_W-1:0];
                    pft_pkg::CFG_CAL:    r_cal    <= i_cfg_data[CAL_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.take) begin
                if (i_operation == pft_pkg::OP_CLEAR) begin
                    r_tally <= '0;
                    r_total <= '0;
                end else begin
                    r_prev <= i_pin_level;
                    if (close) begin
                        r_tally <= '0;
                        r_start <= i_now_ms;
                    end else if (fall && (r_tally != '1)) begin
                        r_tally <= r_tally + 1'b1;
                    end
                end
            end
            if (i_cmd.add) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_elapsed <= elapsed;
            r_wt      <= {{PULSE_COUNT_BITS{1'b0}}, r_window} * {{WIN_W{1'b0}}, r_tally};
        end
        if (i_cmd.mul) begin
            r_num     <= {{(NUM_W - PROD_W){1'b0}}, r_wt} * NUM_W'(pft_pkg::SCALE);
            r_den_raw <= {{CAL_W{1'b0}}, r_elapsed} * {{TIME_W{1'b0}}, r_cal};
        end
        if (i_cmd.scale) begin
            r_den <= {2'b00, r_den_raw} + {1'b0, r_den_raw, 1'b0};
            r_rem <= '0;
            r_quo <= r_num;
        end
        if (i_cmd.step) begin
            r_rem <= ge ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
        if (i_cmd.add) begin
            r_out <= n_total;
        end
    end

endmodule

@@ design/pulse_flow_totalizer.sv @@
// Top level of the pulse flow totalizer: controller, datapath and checks.
//
//  channel  direction  handshake               payload
//  in       to block   i_in_valid/o_in_stall   i_operation, i_now_ms, i_pin_level
//  out      from block o_out_valid/i_out_stall o_total_ml
//  cfg      to block   i_cfg_we                i_cfg_addr, i_cfg_data
//
// A clear or a sample that keeps the window open completes at intake.
// A closing sample goes on through the multiply states S_MUL and S_SCALE,
// the shift-subtract divider at one quotient bit per cycle, and S_ADD for
// the total update.
// The update waits while the previous result is still held by i_out_stall.
// Reset is synchronous and active low; it restores the window and calibration
// registers and zeroes the tally, window start, total and output valid.
`include "pulse_flow_totalizer_macros.svh"

module pulse_flow_totalizer #(
    parameter int PULSE_COUNT_BITS = pft_pkg::PULSE_COUNT_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pft_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [pft_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_operation,
    input  logic [pft_pkg::TIME_W-1:0]     i_now_ms,
    input  logic                           i_pin_level,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [pft_pkg::TOTAL_W-1:0]    o_total_ml
);

    pft_pkg::t_dp_cmd  cmd;
    pft_pkg::t_dp_stat stat;

    pft_ctrl #(
        .PULSE_COUNT_BITS(PULSE_COUNT_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    pft_dp #(
        .PULSE_COUNT_BITS(PULSE_COUNT_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .i_operation (i_operation),
        .i_now_ms    (i_now_ms),
        .i_pin_level (i_pin_level),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_total_ml  (o_total_ml)
    );

    `PFT_ASSERT_NOW(a_no_overwrite, cmd.add, !(o_out_valid && i_out_stall))
    `PFT_ASSERT_NEXT(a_add_shows, cmd.add, o_out_valid)
    `PFT_ASSERT_NEXT(a_clear_silent, cmd.take && (i_operation == pft_pkg::OP_CLEAR),
        !$rose(o_out_valid))
    `PFT_ASSERT_NOW(a_busy_in_div, cmd.step, o_in_stall && !cmd.take)

endmodule
